### rtl/rrss_pkg.sv
// shared types and constants for the round robin slice scheduler
`timescale 1ns / 1ps
`default_nettype none

package rrss_pkg;

    localparam int ID_W      = 16;
    localparam int ARR_W     = 16;
    localparam int BURST_W   = 16;
    localparam int QUANTUM_W = 16;
    localparam int TIME_W    = 21;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SLICE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_SLICE   = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_REFUSED = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] remaining;
    } entry_t;

    typedef struct packed {
        logic   load_en;
        logic   slice_en;
        logic   rotate;
        entry_t new_entry;
        entry_t front_entry;
    } cell_ctrl_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   slice_proc;
        logic [TIME_W-1:0] slice_start;
        logic [TIME_W-1:0] slice_end;
        logic              proc_finished;
        logic              schedule_last;
    } result_t;

endpackage

`default_nettype wire

### rtl/rrss_cell.sv
// one queue slot: sorted insert shifts right, slice shifts left with rotate
`timescale 1ns / 1ps
`default_nettype none

module rrss_cell (
    input  wire logic                clk,
    input  wire rrss_pkg::cell_ctrl_t ctrl,
    input  wire logic                occupied,
    input  wire logic                rot_here,
    input  wire logic                left_keep,
    input  wire rrss_pkg::entry_t    left_entry,
    input  wire rrss_pkg::entry_t    right_entry,
    output logic                     keep,
    output rrss_pkg::entry_t         entry
);
    import rrss_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign keep  = occupied && (entry_reg.arrival <= ctrl.new_entry.arrival);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_en)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? ctrl.new_entry : left_entry;
            end
        end
        else if (ctrl.slice_en)
        begin
            entry_next = (rot_here && ctrl.rotate) ? ctrl.front_entry : right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

### rtl/rrss_out_buf.sv
// two-entry result buffer between the queue and the output channel
`timescale 1ns / 1ps
`default_nettype none

module rrss_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rrss_pkg::result_t push_data,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rrss_pkg::result_t      out_data
);
    import rrss_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    head_reg;
    result_t    head_next;
    result_t    tail_reg;
    result_t    tail_next;
    logic       pop;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push && pop)
        begin
            if (cnt_reg == 2'd1)
            begin
                head_next = push_data;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
        else if (pop)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

### rtl/round_robin_slice_scheduler.sv
// round robin slice scheduler top level: command decode, queue cells, result buffer
//
// Usage:
//   input channel (in_valid / in_stall) carries one command item: load a
//   process, produce the next slice, or clear the table. Every command but
//   code 3 yields exactly one result item on the output channel
//   (out_valid / out_stall); code 3 is taken and dropped.
//   cfg channel (cfg_valid / cfg_ready) writes the quantum; cfg_ready is
//   always high. Write it only while the block is idle.
//   An accepted command's result is registered before it reaches the output.
//   One command is taken per cycle while in_stall is low: the sorted insert
//   and the queue rotation each finish in a single pass through the queue cells.
//   Results wait in a two-entry buffer; in_stall rises only when both entries
//   are held and falls in the cycle after the receiver takes one, so a
//   stalled receiver backs up the input after at most two waiting items.
//   Reset empties the queue, stops the clock at zero, clears the run flag,
//   sets the quantum to 4 and drops any buffered results.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_slice_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rrss_pkg::CMD_W-1:0]    command,
    input  wire logic [rrss_pkg::ID_W-1:0]     proc_id,
    input  wire logic [rrss_pkg::ARR_W-1:0]    arrival_time,
    input  wire logic [rrss_pkg::BURST_W-1:0]  burst_time,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [rrss_pkg::STATUS_W-1:0]      status,
    output logic [rrss_pkg::ID_W-1:0]          slice_proc,
    output logic [rrss_pkg::TIME_W-1:0]        slice_start,
    output logic [rrss_pkg::TIME_W-1:0]        slice_end,
    output logic                               proc_finished,
    output logic                               schedule_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rrss_pkg::QUANTUM_W-1:0] quantum
);
    import rrss_pkg::*;

    localparam int CW = $clog2(MAX_PROCS + 1);

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [TIME_W-1:0]    time_reg;
    logic [TIME_W-1:0]    time_next;
    logic                 started_reg;
    logic                 started_next;
    logic [QUANTUM_W-1:0] quantum_reg;

    logic                 in_accept;
    cmd_t                 cmd;
    logic                 tbl_full;
    logic                 buf_full;
    logic                 push;
    result_t              res;
    result_t              out_res;
    cell_ctrl_t           ctrl;

    entry_t               front;
    logic [QUANTUM_W-1:0] q_eff;
    logic                 fin;
    logic [BURST_W-1:0]   len;
    logic [TIME_W-1:0]    start_t;
    logic [TIME_W-1:0]    end_t;

    entry_t               cell_entry [MAX_PROCS];
    logic                 cell_keep  [MAX_PROCS];

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !in_stall;
    assign cmd       = cmd_t'(command);
    assign tbl_full  = (count_reg == CW'(MAX_PROCS));

    // front of queue and slice arithmetic
    assign front   = cell_entry[0];
    assign q_eff   = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
    assign fin     = (front.remaining <= q_eff) || (count_reg == CW'(1));
    assign len     = fin ? front.remaining : q_eff;
    assign start_t = started_reg ? time_reg : TIME_W'(front.arrival);
    assign end_t   = start_t + TIME_W'(len);

    always_comb
    begin
        ctrl                       = '0;
        ctrl.new_entry.id          = proc_id;
        ctrl.new_entry.arrival     = arrival_time;
        ctrl.new_entry.remaining   = burst_time;
        ctrl.front_entry.id        = front.id;
        ctrl.front_entry.arrival   = front.arrival;
        ctrl.front_entry.remaining = front.remaining - q_eff;
        ctrl.rotate                = !fin;
        res                        = '0;
        push                       = 1'b0;
        count_next                 = count_reg;
        time_next                  = time_reg;
        started_next               = started_reg;
        unique case (cmd)
            CMD_LOAD:
            begin
                push = in_accept;
                if (started_reg)
                begin
                    res.status = ST_REFUSED;
                end
                else if (tbl_full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    res.status   = ST_LOADED;
                    ctrl.load_en = in_accept;
                    if (in_accept)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            CMD_SLICE:
            begin
                push = in_accept;
                if (count_reg == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.status        = ST_SLICE;
                    res.slice_proc    = front.id;
                    res.slice_start   = start_t;
                    res.slice_end     = end_t;
                    res.proc_finished = fin;
                    res.schedule_last = fin && (count_reg == CW'(1));
                    ctrl.slice_en     = in_accept;
                    if (in_accept)
                    begin
                        started_next = 1'b1;
                        time_next    = end_t;
                        if (fin)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                push       = in_accept;
                res.status = ST_CLEARED;
                if (in_accept)
                begin
                    count_next   = '0;
                    time_next    = '0;
                    started_next = 1'b0;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            time_reg    <= '0;
            started_reg <= 1'b0;
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            count_reg   <= count_next;
            time_reg    <= time_next;
            started_reg <= started_next;
            if (cfg_valid && cfg_ready)
            begin
                quantum_reg <= quantum;
            end
        end
    end

    // row of queue cells
    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_cell
        logic   occ;
        logic   rot;
        logic   lkeep;
        entry_t lent;
        entry_t rent;

        assign occ = (CW'(i) < count_reg);
        assign rot = (CW'(i + 1) == count_reg);

        if (i == 0)
        begin : g_first
            assign lkeep = 1'b1;
            assign lent  = ctrl.new_entry;
        end
        else
        begin : g_mid
            assign lkeep = cell_keep[i-1];
            assign lent  = cell_entry[i-1];
        end

        if (i == MAX_PROCS - 1)
        begin : g_last
            assign rent = cell_entry[i];
        end
        else
        begin : g_inner
            assign rent = cell_entry[i+1];
        end

        rrss_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ),
            .rot_here    (rot),
            .left_keep   (lkeep),
            .left_entry  (lent),
            .right_entry (rent),
            .keep        (cell_keep[i]),
            .entry       (cell_entry[i])
        );
    end

    rrss_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign status        = out_res.status;
    assign slice_proc    = out_res.slice_proc;
    assign slice_start   = out_res.slice_start;
    assign slice_end     = out_res.slice_end;
    assign proc_finished = out_res.proc_finished;
    assign schedule_last = out_res.schedule_last;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for the round robin slice scheduler: directed script, then random phases
`timescale 1ns / 1ps
module tb;
    import rrss_pkg::*;

    localparam int SLOTS          = 16;
    localparam int RANDOM_ITEMS   = 950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SCRIPT_LEN     = 13;

    typedef struct packed {
        cmd_t               op;
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic [4:0]         reps;
        logic               typed;
        result_t            want;
    } stim_row_t;

    localparam result_t R_LOADED   = '{ST_LOADED, '0, '0, '0, 1'b0, 1'b0};
    localparam result_t R_FULL     = '{ST_FULL, '0, '0, '0, 1'b0, 1'b0};
    localparam result_t R_EMPTY    = '{ST_EMPTY, '0, '0, '0, 1'b0, 1'b0};
    localparam result_t R_REFUSED  = '{ST_REFUSED, '0, '0, '0, 1'b0, 1'b0};
    localparam result_t R_CLEARED  = '{ST_CLEARED, '0, '0, '0, 1'b0, 1'b0};
    localparam result_t R_ZERO_RUN = '{ST_SLICE, 16'h0000, 21'd0, 21'd0, 1'b1, 1'b0};

    stim_row_t script [SCRIPT_LEN] = '{
        '{CMD_SLICE, 16'h0000, 16'h0000, 16'h0000, 5'd1,  1'b1, R_EMPTY},
        '{CMD_NONE,  16'hffff, 16'hffff, 16'hffff, 5'd1,  1'b0, R_LOADED},
        '{CMD_LOAD,  16'hffff, 16'hffff, 16'hffff, 5'd1,  1'b1, R_LOADED},
        '{CMD_LOAD,  16'h0000, 16'h0000, 16'h0000, 5'd1,  1'b1, R_LOADED},
        '{CMD_LOAD,  16'h1234, 16'h0000, 16'h0005, 5'd1,  1'b1, R_LOADED},
        '{CMD_SLICE, 16'h0000, 16'h0000, 16'h0000, 5'd1,  1'b1, R_ZERO_RUN},
        '{CMD_LOAD,  16'h00aa, 16'h0010, 16'h0003, 5'd1,  1'b1, R_REFUSED},
        '{CMD_SLICE, 16'h0000, 16'h0000, 16'h0000, 5'd4,  1'b0, R_LOADED},
        '{CMD_SLICE, 16'h0000, 16'h0000, 16'h0000, 5'd1,  1'b1, R_EMPTY},
        '{CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 5'd1,  1'b1, R_CLEARED},
        '{CMD_LOAD,  16'h5a5a, 16'h0007, 16'h0002, 5'd16, 1'b1, R_LOADED},
        '{CMD_LOAD,  16'ha5a5, 16'h8000, 16'h0001, 5'd1,  1'b1, R_FULL},
        '{CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 5'd1,  1'b1, R_CLEARED}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     command;
    logic [ID_W-1:0]      proc_id;
    logic [ARR_W-1:0]     arrival_time;
    logic [BURST_W-1:0]   burst_time;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      slice_proc;
    logic [TIME_W-1:0]    slice_start;
    logic [TIME_W-1:0]    slice_end;
    logic                 proc_finished;
    logic                 schedule_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [QUANTUM_W-1:0] quantum;

    logic [ID_W-1:0]      sched_id  [SLOTS];
    logic [ARR_W-1:0]     sched_arr [SLOTS];
    logic [BURST_W-1:0]   sched_rem [SLOTS];
    int                   sched_count = 0;
    logic [TIME_W-1:0]    sched_clock = '0;
    bit                   sched_running = 1'b0;
    logic [QUANTUM_W-1:0] sched_quantum = QUANTUM_RESET;

    result_t pending_results [$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      stall_left = 0;
    int      random_sent = 0;
    bit      calm = 1'b0;

    round_robin_slice_scheduler #(
        .MAX_PROCS(SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .proc_id       (proc_id),
        .arrival_time  (arrival_time),
        .burst_time    (burst_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .slice_proc    (slice_proc),
        .slice_start   (slice_start),
        .slice_end     (slice_end),
        .proc_finished (proc_finished),
        .schedule_last (schedule_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .quantum       (quantum)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit schedule_step(input cmd_t op, input logic [ID_W-1:0] id,
                                         input logic [ARR_W-1:0] arr,
                                         input logic [BURST_W-1:0] burst,
                                         output result_t r);
        int                 pos;
        int                 i;
        logic [QUANTUM_W:0] q;
        logic [ID_W-1:0]    pid;
        logic [ARR_W-1:0]   parr;
        logic [BURST_W-1:0] prem;
        logic [TIME_W-1:0]  start;
        bit                 fin;
        r = R_LOADED;
        case (op)
            CMD_LOAD:
            begin
                if (sched_running)
                    r.status = ST_REFUSED;
                else if (sched_count >= SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < sched_count && sched_arr[pos] <= arr)
                        pos++;
                    for (i = sched_count; i > pos; i--)
                    begin
                        sched_id[i]  = sched_id[i-1];
                        sched_arr[i] = sched_arr[i-1];
                        sched_rem[i] = sched_rem[i-1];
                    end
                    sched_id[pos]  = id;
                    sched_arr[pos] = arr;
                    sched_rem[pos] = burst;
                    sched_count++;
                end
                return 1'b1;
            end
            CMD_SLICE:
            begin
                if (sched_count == 0)
                begin
                    r.status = ST_EMPTY;
                    return 1'b1;
                end
                if (!sched_running)
                begin
                    sched_clock   = TIME_W'(sched_arr[0]);
                    sched_running = 1'b1;
                end
                // a zero quantum behaves as one
                q     = (sched_quantum == '0) ? 17'd1 : {1'b0, sched_quantum};
                pid   = sched_id[0];
                parr  = sched_arr[0];
                prem  = sched_rem[0];
                start = sched_clock;
                fin   = ({1'b0, prem} <= q) || (sched_count == 1);
                sched_clock = start + (fin ? TIME_W'(prem) : TIME_W'(q));
                for (i = 1; i < sched_count; i++)
                begin
                    sched_id[i-1]  = sched_id[i];
                    sched_arr[i-1] = sched_arr[i];
                    sched_rem[i-1] = sched_rem[i];
                end
                sched_count--;
                if (!fin)
                begin
                    sched_id[sched_count]  = pid;
                    sched_arr[sched_count] = parr;
                    sched_rem[sched_count] = prem - q[BURST_W-1:0];
                    sched_count++;
                end
                r = '{ST_SLICE, pid, start, sched_clock, fin, fin && sched_count == 0};
                return 1'b1;
            end
            CMD_CLEAR:
            begin
                sched_count   = 0;
                sched_clock   = '0;
                sched_running = 1'b0;
                r.status      = ST_CLEARED;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic int pick_gap();
        int sel;
        if (calm)
            return 0;
        sel = $urandom_range(99);
        if (sel < 60)
            return 0;
        if (sel < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 10);
    endfunction

    function automatic logic [QUANTUM_W-1:0] pick_quantum();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hffff;
            3, 4, 5: return 16'($urandom_range(8, 1));
            6, 7:    return 16'($urandom_range(64, 1));
            8:       return 16'($urandom_range(65535, 1));
            default: return QUANTUM_RESET;
        endcase
    endfunction

    function automatic logic [ARR_W-1:0] pick_arrival();
        int sel;
        sel = $urandom_range(19);
        if (sel < 10)
            return 16'($urandom_range(7));
        if (sel < 17)
            return 16'($urandom_range(65535));
        return (sel == 17) ? 16'h0000 : 16'hffff;
    endfunction

    function automatic logic [BURST_W-1:0] pick_burst();
        int sel;
        sel = $urandom_range(19);
        if (sel < 3)
            return '0;
        if (sel < 5)
            return 16'hffff;
        if (sel < 14)
            return 16'($urandom_range(24, 1));
        return 16'($urandom_range(65535));
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(9) < 3)
            return 16'($urandom_range(3));
        return 16'($urandom_range(65535));
    endfunction

    task automatic send_item(input cmd_t op, input logic [ID_W-1:0] id,
                             input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                             input bit typed, input result_t want);
        result_t predicted;
        int      gap;
        in_valid     <= 1'b1;
        command      <= op;
        proc_id      <= id;
        arrival_time <= arr;
        burst_time   <= burst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (schedule_step(op, id, arr, burst, predicted))
            pending_results.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input cmd_t op, input logic [ID_W-1:0] id,
                         input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst);
        send_item(op, id, arr, burst, 1'b0, R_LOADED);
        if (op != CMD_NONE)
            random_sent++;
    endtask

    task automatic issue_noise();
        issue(cmd_t'($urandom_range(3)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 16'($urandom_range(65535)));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // command code 3 leaves nothing behind to wait for, so allow its latency
        repeat (3) @(posedge clk);
    endtask

    task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
        cfg_valid <= 1'b1;
        quantum   <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        sched_quantum = value;
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want_v,
                               input logic [TIME_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none got status %0d",
                         $time, status);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", TIME_W'(want.status), TIME_W'(status));
                check_field("slice_proc", TIME_W'(want.slice_proc), TIME_W'(slice_proc));
                check_field("slice_start", want.slice_start, slice_start);
                check_field("slice_end", want.slice_end, slice_end);
                check_field("proc_finished", TIME_W'(want.proc_finished),
                            TIME_W'(proc_finished));
                check_field("schedule_last", TIME_W'(want.schedule_last),
                            TIME_W'(schedule_last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(4) == 0)
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 10)
                                                      : $urandom_range(3, 1);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int row;
        int phase;
        int nload;
        int sel;
        int k;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_NONE;
        proc_id      <= '0;
        arrival_time <= '0;
        burst_time   <= '0;
        cfg_valid    <= 1'b0;
        quantum      <= QUANTUM_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < SCRIPT_LEN; row++)
            repeat (script[row].reps)
                send_item(script[row].op, script[row].id, script[row].arr,
                          script[row].burst, script[row].typed, script[row].want);

        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            calm = (phase % 6 == 5);
            if (phase % 3 == 0)
            begin
                drain_results();
                write_quantum(pick_quantum());
            end
            if ($urandom_range(9) < 8)
                issue(CMD_CLEAR, pick_id(), pick_arrival(), pick_burst());

            sel = $urandom_range(9);
            nload = (sel < 6) ? $urandom_range(8, 1)
                  : (sel < 9) ? $urandom_range(16, 9) : $urandom_range(19, 17);
            for (k = 0; k < nload; k++)
            begin
                if ($urandom_range(11) == 0)
                    issue_noise();
                issue(CMD_LOAD, pick_id(), pick_arrival(), pick_burst());
            end

            for (k = 0; k < 60 && sched_count > 0; k++)
            begin
                if ($urandom_range(9) == 0)
                    issue(CMD_LOAD, pick_id(), pick_arrival(), pick_burst());
                else if ($urandom_range(19) == 0)
                    issue_noise();
                issue(CMD_SLICE, pick_id(), pick_arrival(), pick_burst());
            end
            repeat ($urandom_range(2))
                issue(CMD_SLICE, pick_id(), pick_arrival(), pick_burst());
            phase++;
        end

        drain_results();
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
